FILE: sv/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/stt_pkg.sv
// Shared types, codes and keyword tables for the source text tokenizer.
package stt_pkg;

    localparam int DEF_OFFSET_WIDTH = 32;
    localparam int DEF_LENGTH_WIDTH = 16;
    localparam int DEF_QUEUE_DEPTH  = 4;

    // Longest keyword, in characters
    localparam int KW_MAX_LEN = 6;
    localparam int KW_INT_LEN = 3;
    localparam int KW_DBL_LEN = 6;
    localparam int KW_PRT_LEN = 6;

    typedef enum logic [3:0] {
        KIND_END       = 4'd0,
        KIND_IDENT     = 4'd1,
        KIND_INT_LIT   = 4'd2,
        KIND_DBL_LIT   = 4'd3,
        KIND_KW_INT    = 4'd4,
        KIND_KW_DOUBLE = 4'd5,
        KIND_KW_PRINTF = 4'd6,
        KIND_PLUS      = 4'd7,
        KIND_MINUS     = 4'd8,
        KIND_STAR      = 4'd9,
        KIND_SLASH     = 4'd10,
        KIND_SEMI      = 4'd11,
        KIND_ASSIGN    = 4'd12,
        KIND_LPAREN    = 4'd13,
        KIND_RPAREN    = 4'd14,
        KIND_ERROR     = 4'd15
    } token_kind_t;

    typedef enum logic [2:0] {
        CLASS_SPACE,
        CLASS_ALPHA,
        CLASS_DIGIT,
        CLASS_DOT,
        CLASS_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM
    } scan_mode_t;

    // Classified word handed from front to back
    typedef struct packed {
        logic [7:0]  char_code;
        logic        end_flag;
        char_class_t cls;
        token_kind_t punct_kind;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic second_pending;
        logic scanning;
    } back_status_t;

    // Keywords that have character c at position idx: bit 0 int, bit 1 double, bit 2 printf
    function automatic logic [2:0] kw_match(input logic [7:0] c, input logic [2:0] idx);
        logic [2:0] m;
        m = 3'b000;
        case (idx)
            3'd0: m = {c == "p", c == "d", c == "i"};
            3'd1: m = {c == "r", c == "o", c == "n"};
            3'd2: m = {c == "i", c == "u", c == "t"};
            3'd3: m = {c == "n", c == "b", 1'b0};
            3'd4: m = {c == "t", c == "l", 1'b0};
            3'd5: m = {c == "f", c == "e", 1'b0};
            default: m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

FILE: sv/stt_front.sv
// Front end: accepts source bytes, classifies them and tags each with its offset.
module stt_front #(
    parameter int OFFSET_WIDTH = stt_pkg::DEF_OFFSET_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_ready,
    input  logic [7:0]              char_code,
    input  logic                    end_of_input,
    input  stt_pkg::q_status_t      q_status,
    output logic                    push,
    output stt_pkg::item_t          item,
    output logic [OFFSET_WIDTH-1:0] item_pos
);
    import stt_pkg::*;

    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [OFFSET_WIDTH-1:0] pos_next;
    char_class_t             cls;
    token_kind_t             punct;

    // Accept a word whenever the queue has room
    assign char_ready = !q_status.full;
    assign push       = char_valid && char_ready;

    // Classify the byte
    always_comb
    begin
        if (char_code inside {8'd32, [8'd9:8'd13]})
            cls = CLASS_SPACE;
        else if (char_code inside {["a":"z"], ["A":"Z"], "_"})
            cls = CLASS_ALPHA;
        else if (char_code inside {["0":"9"]})
            cls = CLASS_DIGIT;
        else if (char_code == ".")
            cls = CLASS_DOT;
        else
            cls = CLASS_OTHER;
    end

    // Map single-character tokens; anything else is an error
    always_comb
    begin
        case (char_code)
            "+":     punct = KIND_PLUS;
            "-":     punct = KIND_MINUS;
            "*":     punct = KIND_STAR;
            "/":     punct = KIND_SLASH;
            ";":     punct = KIND_SEMI;
            "=":     punct = KIND_ASSIGN;
            "(":     punct = KIND_LPAREN;
            ")":     punct = KIND_RPAREN;
            default: punct = KIND_ERROR;
        endcase
    end

    assign item.char_code  = char_code;
    assign item.end_flag   = end_of_input;
    assign item.cls        = cls;
    assign item.punct_kind = punct;
    assign item_pos        = pos_reg;

    // Advance the byte offset on every accepted byte; the end mark takes no offset
    assign pos_next = (push && !end_of_input) ? pos_reg + 1'b1 : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

FILE: sv/stt_queue.sv
// Short register queue between the front and back ends.
module stt_queue #(
    parameter int DATA_WIDTH = 16,
    parameter int DEPTH      = stt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] rdata,
    output stt_pkg::q_status_t    status
);
    import stt_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]         wr_ptr_reg;
    logic [PW-1:0]         wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg;
    logic [PW-1:0]         rd_ptr_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  do_push;
    logic                  do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the word at the write pointer
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

FILE: sv/stt_back.sv
// Back end: scanner state machine and token output register.
module stt_back #(
    parameter int OFFSET_WIDTH = stt_pkg::DEF_OFFSET_WIDTH,
    parameter int LENGTH_WIDTH = stt_pkg::DEF_LENGTH_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  stt_pkg::item_t          item,
    input  logic [OFFSET_WIDTH-1:0] item_pos,
    input  logic                    item_avail,
    output logic                    item_pop,
    output logic                    token_valid,
    input  logic                    token_ready,
    output logic [3:0]              token_kind,
    output logic [OFFSET_WIDTH-1:0] start_offset,
    output logic [LENGTH_WIDTH-1:0] token_length,
    output logic                    last_result,
    output stt_pkg::back_status_t   status
);
    import stt_pkg::*;

    // Scanner state
    scan_mode_t              mode_reg;
    scan_mode_t              mode_next;
    logic                    dot_reg;
    logic                    dot_next;
    logic [2:0]              cand_reg;
    logic [2:0]              cand_next;
    logic [LENGTH_WIDTH-1:0] len_reg;
    logic [LENGTH_WIDTH-1:0] len_next;
    logic [OFFSET_WIDTH-1:0] start_reg;
    logic [OFFSET_WIDTH-1:0] start_next;

    // Second token of a word, held until the output frees
    logic                    pend_valid_reg;
    token_kind_t             pend_kind_reg;
    logic [OFFSET_WIDTH-1:0] pend_start_reg;
    logic [LENGTH_WIDTH-1:0] pend_len_reg;

    // Output register
    logic                    out_valid_reg;
    token_kind_t             out_kind_reg;
    logic [OFFSET_WIDTH-1:0] out_start_reg;
    logic [LENGTH_WIDTH-1:0] out_len_reg;
    logic                    out_last_reg;

    logic                    advance;
    logic                    take;
    logic                    absorbed;
    logic                    flush_v;
    token_kind_t             flush_kind;
    token_kind_t             ident_kind;
    logic                    char_v;
    token_kind_t             char_kind;
    logic [LENGTH_WIDTH-1:0] char_len;
    logic [LENGTH_WIDTH-1:0] len_grown;
    logic [2:0]              cand_cont;

    assign advance  = !out_valid_reg || token_ready;
    assign take     = advance && !pend_valid_reg && item_avail;
    assign item_pop = take;

    // Saturating length step and keyword candidates for a continuing identifier
    assign len_grown = (len_reg == '1) ? len_reg : len_reg + 1'b1;
    assign cand_cont = (len_reg < LENGTH_WIDTH'(KW_MAX_LEN))
                       ? (cand_reg & kw_match(item.char_code, len_reg[2:0])) : 3'b000;

    // Resolve the kind of a finished identifier
    always_comb
    begin
        ident_kind = KIND_IDENT;
        if (cand_reg[0] && len_reg == LENGTH_WIDTH'(KW_INT_LEN))
            ident_kind = KIND_KW_INT;
        if (cand_reg[1] && len_reg == LENGTH_WIDTH'(KW_DBL_LEN))
            ident_kind = KIND_KW_DOUBLE;
        if (cand_reg[2] && len_reg == LENGTH_WIDTH'(KW_PRT_LEN))
            ident_kind = KIND_KW_PRINTF;
    end

    // Next scanner state and the tokens this word produces
    always_comb
    begin
        mode_next  = mode_reg;
        dot_next   = dot_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        start_next = start_reg;
        absorbed   = 1'b0;
        flush_v    = 1'b0;
        flush_kind = (mode_reg == MODE_NUM) ? (dot_reg ? KIND_DBL_LIT : KIND_INT_LIT)
                                            : ident_kind;
        char_v     = 1'b0;
        char_kind  = item.punct_kind;
        char_len   = LENGTH_WIDTH'(1);

        if (item.end_flag)
        begin
            // Flush the pending token, then emit the end token
            flush_v   = (mode_reg != MODE_IDLE);
            mode_next = MODE_IDLE;
            dot_next  = 1'b0;
            cand_next = 3'b000;
            len_next  = '0;
            char_v    = 1'b1;
            char_kind = KIND_END;
            char_len  = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (item.cls inside {CLASS_ALPHA, CLASS_DIGIT})
                    begin
                        absorbed  = 1'b1;
                        cand_next = cand_cont;
                        len_next  = len_grown;
                    end
                    else
                        flush_v = 1'b1;
                end
                MODE_NUM:
                begin
                    if (item.cls == CLASS_DIGIT)
                    begin
                        absorbed = 1'b1;
                        len_next = len_grown;
                    end
                    else if (item.cls == CLASS_DOT && !dot_reg)
                    begin
                        absorbed = 1'b1;
                        dot_next = 1'b1;
                        len_next = len_grown;
                    end
                    else
                        flush_v = 1'b1;
                end
                default: ;
            endcase

            if (!absorbed)
            begin
                // Emit any pending token, then handle the byte on its own
                mode_next = MODE_IDLE;
                dot_next  = 1'b0;
                cand_next = 3'b000;
                len_next  = '0;
                case (item.cls)
                    CLASS_SPACE: ;
                    CLASS_ALPHA:
                    begin
                        mode_next  = MODE_IDENT;
                        start_next = item_pos;
                        cand_next  = kw_match(item.char_code, 3'd0);
                        len_next   = LENGTH_WIDTH'(1);
                    end
                    CLASS_DIGIT:
                    begin
                        mode_next  = MODE_NUM;
                        start_next = item_pos;
                        len_next   = LENGTH_WIDTH'(1);
                    end
                    default:
                        char_v = 1'b1;
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            dot_reg        <= 1'b0;
            cand_reg       <= 3'b000;
            len_reg        <= '0;
            start_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg  <= mode_next;
                dot_reg   <= dot_next;
                cand_reg  <= cand_next;
                len_reg   <= len_next;
                start_reg <= start_next;
            end
            if (advance)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    pend_valid_reg <= 1'b0;
                end
                else if (take)
                begin
                    out_valid_reg  <= flush_v || char_v;
                    pend_valid_reg <= flush_v && char_v;
                end
                else
                    out_valid_reg <= 1'b0;
            end
        end
    end

    // Token payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (pend_valid_reg)
            begin
                out_kind_reg  <= pend_kind_reg;
                out_start_reg <= pend_start_reg;
                out_len_reg   <= pend_len_reg;
                out_last_reg  <= 1'b1;
            end
            else if (take)
            begin
                if (flush_v)
                begin
                    out_kind_reg  <= flush_kind;
                    out_start_reg <= start_reg;
                    out_len_reg   <= len_reg;
                    out_last_reg  <= !char_v;
                end
                else
                begin
                    out_kind_reg  <= char_kind;
                    out_start_reg <= item_pos;
                    out_len_reg   <= char_len;
                    out_last_reg  <= 1'b1;
                end
                pend_kind_reg  <= char_kind;
                pend_start_reg <= item_pos;
                pend_len_reg   <= char_len;
            end
        end
    end

    assign token_valid           = out_valid_reg;
    assign token_kind            = out_kind_reg;
    assign start_offset          = out_start_reg;
    assign token_length          = out_len_reg;
    assign last_result           = out_last_reg;
    assign status.second_pending = pend_valid_reg;
    assign status.scanning       = (mode_reg != MODE_IDLE);

endmodule

FILE: sv/source_text_tokenizer_unit.sv
// An accepted byte is written to the queue, then scanned into the output register.
// Throughput: one byte per cycle while the queue has room; a byte that closes a token
//   and makes one more stalls on the pending token; the four-word queue absorbs it.
// The scanner state machine emits at most one token per cycle through its output register.
// Reset clears the byte offset, scanner state, queue and output valid at once.
`include "assert_macros.svh"

module source_text_tokenizer_unit #(
    parameter int OFFSET_WIDTH = stt_pkg::DEF_OFFSET_WIDTH,
    parameter int LENGTH_WIDTH = stt_pkg::DEF_LENGTH_WIDTH,
    parameter int QUEUE_DEPTH  = stt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_ready,
    input  logic [7:0]              char_code,
    input  logic                    end_of_input,
    output logic                    token_valid,
    input  logic                    token_ready,
    output logic [3:0]              token_kind,
    output logic [OFFSET_WIDTH-1:0] start_offset,
    output logic [LENGTH_WIDTH-1:0] token_length,
    output logic                    last_result
);
    import stt_pkg::*;

    localparam int IW = $bits(item_t);
    localparam int QW = IW + OFFSET_WIDTH;

    item_t                   f_item;
    logic [OFFSET_WIDTH-1:0] f_pos;
    logic                    q_push;
    logic                    q_pop;
    logic [QW-1:0]           q_rdata;
    q_status_t               q_status;
    back_status_t            b_status;
    logic                    out_first;
    logic                    out_end;

    stt_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .q_status     (q_status),
        .push         (q_push),
        .item         (f_item),
        .item_pos     (f_pos)
    );

    stt_queue #(
        .DATA_WIDTH (QW),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  ({f_pos, f_item}),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    stt_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_t'(q_rdata[IW-1:0])),
        .item_pos     (q_rdata[QW-1:IW]),
        .item_avail   (!q_status.empty),
        .item_pop     (q_pop),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .last_result  (last_result),
        .status       (b_status)
    );

    assign out_first = token_valid && !last_result;
    assign out_end   = token_valid && (token_kind == KIND_END);

    // Queue and scanner consistency
    `ASSERT_IMPLY(a_pop_nonempty, q_pop, !q_status.empty, "pop from empty queue")
    `ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_status.empty, "pushed word lost")
    `ASSERT_IMPLY(a_first_of_two, out_first, b_status.second_pending, "lone first token")
    `ASSERT_IMPLY(a_end_token, out_end, token_length == '0 && last_result, "bad end token")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the source text tokenizer: byte stream in, token stream checked.
`timescale 1ns / 1ps

module testbench;
    import stt_pkg::*;

    localparam int OFF_W = DEF_OFFSET_WIDTH;
    localparam int LEN_W = DEF_LENGTH_WIDTH;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
    localparam int STUCK_LIMIT = 1000;
    localparam int RANDOM_BYTES = 1550;

    typedef struct {
        token_kind_t      kind;
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             last;
    } token_t;

    typedef struct {
        logic [7:0] code;
        bit         eoi;
    } src_byte_t;

    // Token predictor plus the queue of tokens still owed by the block
    class token_scoreboard;
        token_t           expected_tokens[$];
        token_t           fresh[$];
        int               failures;
        int               checked;
        scan_mode_t       mode = MODE_IDLE;
        bit               dot_seen;
        logic [2:0]       kw_live = 3'b000;
        logic [LEN_W-1:0] pend_len = '0;
        logic [OFF_W-1:0] pend_start = '0;
        logic [OFF_W-1:0] position = '0;
        string            kw_text[3] = '{"int", "double", "printf"};
        token_kind_t      kw_kind[3] = '{KIND_KW_INT, KIND_KW_DOUBLE, KIND_KW_PRINTF};

        function bit is_space(logic [7:0] c);
            return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function void emit(token_kind_t kind, logic [OFF_W-1:0] start, logic [LEN_W-1:0] len);
            token_t t;
            t.kind  = kind;
            t.start = start;
            t.len   = len;
            t.last  = 1'b0;
            fresh.push_back(t);
        endfunction

        function void grow();
            if (pend_len != LEN_MAX)
                pend_len++;
        endfunction

        // Drop keywords that no longer match at the current position
        function void narrow(logic [7:0] c);
            for (int k = 0; k < 3; k++)
                if (pend_len >= kw_text[k].len() || kw_text[k][int'(pend_len)] != c)
                    kw_live[k] = 1'b0;
        endfunction

        // Emit the pending identifier or number and return to idle
        function void close_token();
            token_kind_t kind;
            if (mode == MODE_IDENT)
            begin
                kind = KIND_IDENT;
                for (int k = 0; k < 3; k++)
                    if (kw_live[k] && pend_len == kw_text[k].len() && pend_len != LEN_MAX)
                        kind = kw_kind[k];
                emit(kind, pend_start, pend_len);
            end
            else if (mode == MODE_NUM)
            begin
                if (dot_seen)
                    emit(KIND_DBL_LIT, pend_start, pend_len);
                else
                    emit(KIND_INT_LIT, pend_start, pend_len);
            end
            mode     = MODE_IDLE;
            dot_seen = 1'b0;
            kw_live  = 3'b000;
            pend_len = '0;
        endfunction

        // Predict the tokens caused by one accepted word
        function void note_byte(logic [7:0] c, bit eoi);
            fresh.delete();
            if (eoi)
            begin
                close_token();
                emit(KIND_END, position, '0);
            end
            else
            begin
                if (mode == MODE_IDENT)
                begin
                    if (is_alpha(c) || is_digit(c) || c == "_")
                    begin
                        narrow(c);
                        grow();
                    end
                    else
                    begin
                        close_token();
                    end
                end
                else if (mode == MODE_NUM)
                begin
                    if (is_digit(c))
                    begin
                        grow();
                    end
                    else if (c == "." && !dot_seen)
                    begin
                        dot_seen = 1'b1;
                        grow();
                    end
                    else
                    begin
                        close_token();
                    end
                end
                // Handle a byte that no pending token took
                if (mode == MODE_IDLE)
                begin
                    if (is_alpha(c) || c == "_")
                    begin
                        mode       = MODE_IDENT;
                        pend_start = position;
                        kw_live    = 3'b111;
                        narrow(c);
                        pend_len   = LEN_ONE;
                    end
                    else if (is_digit(c))
                    begin
                        mode       = MODE_NUM;
                        pend_start = position;
                        dot_seen   = 1'b0;
                        pend_len   = LEN_ONE;
                    end
                    else if (!is_space(c))
                    begin
                        case (c)
                            "+":     emit(KIND_PLUS, position, LEN_ONE);
                            "-":     emit(KIND_MINUS, position, LEN_ONE);
                            "*":     emit(KIND_STAR, position, LEN_ONE);
                            "/":     emit(KIND_SLASH, position, LEN_ONE);
                            ";":     emit(KIND_SEMI, position, LEN_ONE);
                            "=":     emit(KIND_ASSIGN, position, LEN_ONE);
                            "(":     emit(KIND_LPAREN, position, LEN_ONE);
                            ")":     emit(KIND_RPAREN, position, LEN_ONE);
                            default: emit(KIND_ERROR, position, LEN_ONE);
                        endcase
                    end
                end
                position++;
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                expected_tokens.push_back(fresh[i]);
        endfunction

        function void flag(string field, longint unsigned exp_val, longint unsigned act_val);
            failures++;
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
        endfunction

        // Compare one accepted token with the oldest prediction
        function void check_token(logic [3:0] kind, logic [OFF_W-1:0] start,
                                  logic [LEN_W-1:0] len, logic last);
            token_t t;
            checked++;
            if (expected_tokens.size() == 0)
            begin
                failures++;
                $error("unexpected token: kind %0d at offset %0d", kind, start);
                return;
            end
            t = expected_tokens.pop_front();
            if (kind !== t.kind)
                flag("token_kind", t.kind, kind);
            if (start !== t.start)
                flag("start_offset", t.start, start);
            if (len !== t.len)
                flag("token_length", t.len, len);
            if (last !== t.last)
                flag("last_result", t.last, last);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             char_valid;
    logic             char_ready;
    logic [7:0]       char_code;
    logic             end_of_input;
    logic             token_valid;
    logic             token_ready = 1'b0;
    logic [3:0]       token_kind;
    logic [OFF_W-1:0] start_offset;
    logic [LEN_W-1:0] token_length;
    logic             last_result;

    token_scoreboard sb;
    src_byte_t       stream[$];
    bit              no_idle;
    int              stall_left = 0;
    int              stuck_cycles = 0;
    int              bytes_sent;

    source_text_tokenizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .last_result  (last_result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_byte(input logic [7:0] c, input bit eoi);
        src_byte_t b;
        b.code = c;
        b.eoi  = eoi;
        stream.push_back(b);
    endtask

    task automatic push_text(input string s);
        foreach (s[i])
            push_byte(s[i], 1'b0);
    endtask

    // Send every queued word, with random gaps between them
    task automatic drive_stream(input bit rotate);
        int gap;
        foreach (stream[i])
        begin
            if (rotate && i % 120 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            gap = no_idle ? 0 : idle_len();
            if (gap > 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            char_valid   <= 1'b1;
            char_code    <= stream[i].code;
            end_of_input <= stream[i].eoi;
            do @(posedge clk); while (!char_ready);
            sb.note_byte(stream[i].code, stream[i].eoi);
            bytes_sent++;
            @(negedge clk);
        end
        stream.delete();
    endtask

    // Stall the token side at random
    always @(negedge clk)
    begin
        if (no_idle)
        begin
            token_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            token_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 99) < 75)
        begin
            token_ready <= 1'b1;
        end
        else
        begin
            token_ready <= 1'b0;
            stall_left = idle_len();
        end
    end

    // Check every accepted token
    always @(posedge clk)
        if (rst_n && token_valid && token_ready)
            sb.check_token(token_kind, start_offset, token_length, last_result);

    // End the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && char_ready) || (token_valid && token_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("timeout: no word accepted for %0d cycles", STUCK_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        string keywords[3];
        string ident_chars;
        string punct_chars;
        string kw;
        int    r;
        int    n;

        keywords     = '{"int", "double", "printf"};
        ident_chars  = {"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_", "0123456789"};
        punct_chars  = "+-*/;=()";
        sb           = new();
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_code    = 8'h00;
        end_of_input = 1'b0;
        no_idle      = 1'b0;
        bytes_sent   = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: keywords, whitespace, all punctuation, second dot, odd bytes, end flags
        push_text("int\t_Z9=printf(1.2.*;");
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_text("+-/)x");
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        drive_stream(1'b0);

        // Random: mostly lexemes with random content, some noise and stray end flags
        while (stream.size() < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                kw = keywords[$urandom_range(0, 2)];
                case ($urandom_range(0, 2))
                    0: push_text(kw);
                    1: push_text(kw.substr(0, $urandom_range(0, kw.len() - 2)));
                    default:
                    begin
                        push_text(kw);
                        push_byte(ident_chars[$urandom_range(0, 62)], 1'b0);
                    end
                endcase
            end
            else if (r < 30)
            begin
                push_byte(ident_chars[$urandom_range(0, 52)], 1'b0);
                n = $urandom_range(0, 9);
                repeat (n) push_byte(ident_chars[$urandom_range(0, 62)], 1'b0);
            end
            else if (r < 48)
            begin
                n = $urandom_range(1, 5);
                repeat (n) push_byte(8'd48 + 8'($urandom_range(0, 9)), 1'b0);
                case ($urandom_range(0, 3))
                    0: ;
                    1: push_text(".");
                    2: push_text(".25");
                    default: push_text("3.1.4");
                endcase
            end
            else if (r < 66)
            begin
                push_byte(punct_chars[$urandom_range(0, 7)], 1'b0);
            end
            else if (r < 84)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    r = $urandom_range(9, 14);
                    push_byte((r == 14) ? 8'd32 : 8'(r), 1'b0);
                end
            end
            else if (r < 96)
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        push_byte(8'($urandom_range(0, 255)), 1'b1);
        drive_stream(1'b1);

        // Drain and settle
        char_valid <= 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("covered %0d bytes and %0d tokens: keywords, literals, punctuation, errors,",
                 bytes_sent, sb.checked);
        $display("repeated end flags, offsets running past end tokens and random stalls");
        if (sb.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: source_text_tokenizer_unit.f
+incdir+sv
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/stt_back.sv
sv/source_text_tokenizer_unit.sv
sim/testbench.sv
